// ===== rtl/core/variable_delay_line_feedback_defines.svh =====
`ifndef VARIABLE_DELAY_LINE_FEEDBACK_DEFINES_SVH
`define VARIABLE_DELAY_LINE_FEEDBACK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VDLF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdlf check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define VDLF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdlf check failed");

`endif

// ===== rtl/core/vdlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vdlf_pkg;

  localparam int SMP_W   = 16;
  localparam int DT_W    = 24;
  localparam int SR_W    = 18;
  localparam int LL_W    = 16;
  localparam int DT_FRAC = 20;

  localparam int SM_AW = 25;
  localparam int SM_BW = 18;
  localparam int SM_PW = SM_AW + 1 + SM_BW;

  localparam logic REG_SAMPLE_RATE = 1'b0;
  localparam logic REG_LINE_LENGTH = 1'b1;

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  typedef struct packed {
    logic start;
    logic mplier_signed;
  } mul_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/vdlf_serial_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vdlf_serial_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  vdlf_pkg::mul_req_t                  req,
  input  logic signed [vdlf_pkg::SM_AW-1:0]   mcand,
  input  logic        [vdlf_pkg::SM_BW-1:0]   mplier,
  output logic                                done,
  output logic signed [vdlf_pkg::SM_PW-1:0]   prod
);

  localparam int AW   = vdlf_pkg::SM_AW;
  localparam int BW   = vdlf_pkg::SM_BW;
  localparam int CNTW = $clog2(BW);

  logic                busy;
  logic [CNTW-1:0]     cnt;
  logic signed [AW:0]  hi;
  logic [BW-1:0]       lo;
  logic signed [AW-1:0] mc;
  logic                sg;
  logic                last;
  logic signed [AW+1:0] mc_ext;
  logic signed [AW+1:0] addend;
  logic signed [AW+1:0] sum;

  assign last   = (cnt == CNTW'(BW - 1));
  assign mc_ext = {{2{mc[AW-1]}}, mc};

  always_comb begin
    if (lo[0]) begin
      addend = (last && sg) ? -mc_ext : mc_ext;
    end else begin
      addend = '0;
    end
    sum = {hi[AW], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        hi   <= '0;
        lo   <= mplier;
        mc   <= mcand;
        sg   <= req.mplier_signed;
      end else if (busy) begin
        hi  <= sum[AW+1:1];
        lo  <= {sum[0], lo[BW-1:1]};
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign prod = {hi, lo};

endmodule

`default_nettype wire

// ===== rtl/core/variable_delay_line_feedback.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fractional delay line with linear interpolation and feedback.
// Input channel (in_valid / in_stall) carries in_sample, delay_time and
// feedback_gain; one transaction is taken at an edge with in_valid high and
// in_stall low. The output channel (out_valid / out_stall) returns one
// out_sample per input transaction, in order.
// Each item runs through three 18-step shift-add multiplies on one shared
// serial unit (delay scaling, interpolation, feedback), plus position math
// (limit, position, base), two reads of the delay memory through its one
// read port, write-back and output handoff.
// A new input is taken only once the core is back in idle, after the
// previous item has reached the output register. With line_length zero
// the input passes straight through, bypassing the multiplier and memory.
// The finished result sits in an output register; the core returns to idle
// and takes the next input while out_stall holds that result. If a second
// result is ready before the first is taken, the core waits for the slot.
// Reset (rst, synchronous) empties the pipeline, zeroes the write index and
// restores sample_rate 48000 and line_length 0. The memory is not swept:
// a high-water mark of written entries makes never-written entries read as
// zero, so there is no clearing pass after reset.
// Registers over APB: sample_rate at 0x0, line_length at 0x4.

module variable_delay_line_feedback #(
  parameter int unsigned MAX_LENGTH = 32768,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vdlf_pkg::SMP_W-1:0]   in_sample,
  input  logic        [vdlf_pkg::DT_W-1:0]    delay_time,
  input  logic signed [vdlf_pkg::SMP_W-1:0]   feedback_gain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vdlf_pkg::SMP_W-1:0]   out_sample,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [2:0]                   paddr,
  input  logic        [31:0]                  pwdata,
  output logic        [31:0]                  prdata,
  output logic                                pready
);

  localparam int SW   = vdlf_pkg::SMP_W;
  localparam int F    = FRAC_BITS;
  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int LW   = $clog2(MAX_LENGTH + 1);
  localparam int CW   = (LW > vdlf_pkg::LL_W) ? LW : vdlf_pkg::LL_W;
  localparam int BW   = LW + 1;
  localparam int LIMW = LW + F;
  localparam int RPW  = LIMW + 1;
  localparam int DSH  = vdlf_pkg::DT_FRAC - F;
  localparam int PTOP = vdlf_pkg::DT_W + vdlf_pkg::SR_W - 1;
  localparam int PW   = PTOP - DSH + 1;
  localparam int CMPW = (PW > LIMW) ? PW : LIMW;
  localparam int AX   = vdlf_pkg::SM_AW;
  localparam int BX   = vdlf_pkg::SM_BW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_DLY, S_LIMIT, S_POS, S_BASE, S_RD_A, S_RD_B, S_RD_C,
    S_MUL_INT, S_INTERP, S_MUL_FB, S_WRITE, S_FINISH
  } state_t;

  state_t state;

  logic [vdlf_pkg::SR_W-1:0] sample_rate;
  logic [vdlf_pkg::LL_W-1:0] line_length;

  logic signed [SW-1:0] x_reg;
  logic signed [SW-1:0] fb_reg;
  logic signed [SW-1:0] a_smp;
  logic signed [SW-1:0] y;
  logic [LW-1:0]        len;
  logic [LW-1:0]        fill;
  logic [AW-1:0]        widx;
  logic [AW-1:0]        base;
  logic [LIMW-1:0]      dfx;
  logic [RPW-1:0]       rpos;

  logic signed [SW-1:0] mem [MAX_LENGTH];
  logic signed [SW-1:0] rdata;
  logic [AW-1:0]        raddr;

  vdlf_pkg::mul_req_t      m_req;
  logic signed [AX-1:0]    m_a;
  logic [BX-1:0]           m_b;
  logic                    m_done;
  logic signed [vdlf_pkg::SM_PW-1:0] m_prod;
  logic                    mul_go;

  logic                 in_acc;
  logic [CW-1:0]        ll_ext;
  logic [LW-1:0]        len_cur;
  logic [LIMW-1:0]      limit;
  logic [PW-1:0]        dfx_raw;
  logic [LIMW-1:0]      dfx_next;
  logic [RPW-1:0]       rpos_next;
  logic [BW-1:0]        base_raw;
  logic [BW-1:0]        base_wrap;
  logic [LW-1:0]        inc;
  logic [AW-1:0]        nxt_idx;
  logic signed [SW-1:0] b_cur;
  logic [SW:0]          diff;
  logic [SW:0]          y17;
  logic signed [SW-1:0] y_int;
  logic [SW:0]          fbp;
  logic [SW+1:0]        s18;
  logic signed [SW-1:0] w;
  logic [LW-1:0]        widx_inc;

  vdlf_serial_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (m_req),
    .mcand  (m_a),
    .mplier (m_b),
    .done   (m_done),
    .prod   (m_prod)
  );

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign mul_go   = (in_acc && (len_cur != '0)) || (state == S_RD_C) || (state == S_INTERP);

  always_comb begin
    unique case (paddr[2])
      vdlf_pkg::REG_SAMPLE_RATE: prdata = 32'(sample_rate);
      vdlf_pkg::REG_LINE_LENGTH: prdata = 32'(line_length);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    ll_ext  = CW'(line_length);
    len_cur = (ll_ext > CW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : ll_ext[LW-1:0];

    limit   = {len, {F{1'b0}}};
    dfx_raw = m_prod[PTOP:DSH];
    if (CMPW'(dfx_raw) > CMPW'(limit)) begin
      dfx_next = limit;
    end else begin
      dfx_next = LIMW'(dfx_raw);
    end

    rpos_next = RPW'({widx, {F{1'b0}}}) + RPW'(limit) - RPW'(dfx);
    base_raw  = rpos[RPW-1:F];
    base_wrap = (base_raw >= BW'(len)) ? base_raw - BW'(len) : base_raw;

    inc     = LW'(base) + 1'b1;
    nxt_idx = (inc >= len) ? '0 : AW'(inc);

    b_cur = (LW'(nxt_idx) < fill) ? rdata : '0;
    diff  = {b_cur[SW-1], b_cur} - {a_smp[SW-1], a_smp};

    y17   = {a_smp[SW-1], a_smp} + m_prod[F+SW:F];
    y_int = y17[SW-1:0];

    fbp = m_prod[2*SW-1:SW-1];
    s18 = {{2{x_reg[SW-1]}}, x_reg} + {fbp[SW], fbp};
    if (!s18[SW+1] && (s18[SW:SW-1] != 2'b00)) begin
      w = {1'b0, {(SW-1){1'b1}}};
    end else if (s18[SW+1] && (s18[SW:SW-1] != 2'b11)) begin
      w = {1'b1, {(SW-1){1'b0}}};
    end else begin
      w = s18[SW-1:0];
    end

    widx_inc = LW'(widx) + 1'b1;
    raddr    = (state == S_RD_A) ? base : nxt_idx;
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[widx] <= w;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      sample_rate <= vdlf_pkg::SR_RESET;
      line_length <= '0;
      widx        <= '0;
      fill        <= '0;
      m_req       <= '0;
    end else begin
      m_req.start <= mul_go;

      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          vdlf_pkg::REG_SAMPLE_RATE: sample_rate <= pwdata[vdlf_pkg::SR_W-1:0];
          vdlf_pkg::REG_LINE_LENGTH: line_length <= pwdata[vdlf_pkg::LL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            x_reg  <= in_sample;
            fb_reg <= feedback_gain;
            if (len_cur == '0) begin
              y     <= in_sample;
              state <= S_FINISH;
            end else begin
              len                 <= len_cur;
              widx                <= (LW'(widx) >= len_cur) ? '0 : widx;
              m_a                 <= AX'({1'b0, delay_time});
              m_b                 <= BX'(sample_rate);
              m_req.mplier_signed <= 1'b0;
              state               <= S_MUL_DLY;
            end
          end
        end
        S_MUL_DLY: begin
          if (m_done) begin
            state <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          dfx   <= dfx_next;
          state <= S_POS;
        end
        S_POS: begin
          rpos  <= rpos_next;
          state <= S_BASE;
        end
        S_BASE: begin
          base  <= AW'(base_wrap);
          state <= S_RD_A;
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          a_smp <= (LW'(base) < fill) ? rdata : '0;
          state <= S_RD_C;
        end
        S_RD_C: begin
          m_a                 <= {{(AX-SW-1){diff[SW]}}, diff};
          m_b                 <= BX'(rpos[F-1:0]);
          m_req.mplier_signed <= 1'b0;
          state               <= S_MUL_INT;
        end
        S_MUL_INT: begin
          if (m_done) begin
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          y                   <= y_int;
          m_a                 <= {{(AX-SW){fb_reg[SW-1]}}, fb_reg};
          m_b                 <= {{(BX-SW){y_int[SW-1]}}, y_int};
          m_req.mplier_signed <= 1'b1;
          state               <= S_MUL_FB;
        end
        S_MUL_FB: begin
          if (m_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (LW'(widx) >= fill) begin
            fill <= widx_inc;
          end
          widx  <= (widx_inc >= len) ? '0 : AW'(widx_inc);
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_sample <= y;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vdlf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "variable_delay_line_feedback_defines.svh"

module vdlf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [vdlf_pkg::SMP_W-1:0] out_sample
);

  // hold a stalled result
  `VDLF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample))

  // busy after taking a transaction
  `VDLF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a new result only comes out of a busy core
  `VDLF_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

  // idle and empty right after reset
  `VDLF_ASSERT_IMP(a_reset_idle, $past(rst), !in_stall && !out_valid)

endmodule

bind variable_delay_line_feedback vdlf_checker u_vdlf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);

`default_nettype wire
